### hdl/doubly_linked_list_cursor_engine_defines.svh
// Assertion macros shared by the list engine.
`ifndef DOUBLY_LINKED_LIST_CURSOR_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLLC_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLLC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dllc_pkg.sv
`timescale 1ns / 1ps

package dllc_pkg;

  localparam int NODES_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int KIND_W          = 4;
  localparam int LEN_W           = 5;
  localparam int PORT_VW         = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR      = 4'd0,
    KIND_INS_FIRST  = 4'd1,
    KIND_INS_LAST   = 4'd2,
    KIND_GO_FIRST   = 4'd3,
    KIND_GO_LAST    = 4'd4,
    KIND_DEL_FIRST  = 4'd5,
    KIND_DEL_LAST   = 4'd6,
    KIND_DEL_AFTER  = 4'd7,
    KIND_DEL_BEFORE = 4'd8,
    KIND_INS_AFTER  = 4'd9,
    KIND_INS_BEFORE = 4'd10,
    KIND_SET        = 4'd11,
    KIND_NEXT       = 4'd12,
    KIND_PREV       = 4'd13,
    KIND_READ       = 4'd14
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NOP  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [PORT_VW-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic                      is_active;
    logic [LEN_W-1:0]          length;
    logic signed [PORT_VW-1:0] first_value;
    logic signed [PORT_VW-1:0] last_value;
    logic signed [PORT_VW-1:0] active_value;
  } rsp_t;

endpackage

### hdl/dllc_cmd_reg.sv
`timescale 1ns / 1ps

module dllc_cmd_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dllc_pkg::cmd_t cmd,
  input  logic          fire,
  output logic          held,
  output dllc_pkg::cmd_t held_cmd
);
  import dllc_pkg::*;

  // The register frees up in the same cycle that its word moves on.
  assign cmd_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_ready) begin
      held <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      held_cmd <= cmd;
    end
  end

endmodule

### hdl/dllc_core.sv
`timescale 1ns / 1ps

module dllc_core #(
  parameter int NODES       = dllc_pkg::NODES_DEF,
  parameter int VALUE_WIDTH = dllc_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  dllc_pkg::cmd_t cmd,
  output dllc_pkg::rsp_t result
);
  import dllc_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int IW = $clog2(NODES) + 1;
  localparam int CW = $clog2(NODES + 1);
  // An index equal to NODES marks "no node".
  localparam logic [IW-1:0] NONE = IW'(NODES);

  typedef logic [IW-1:0]          ix_t;
  typedef logic [AW-1:0]          slot_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  val_t node_store [NODES];
  ix_t  next_link  [NODES];
  ix_t  prev_link  [NODES];

  logic [NODES-1:0] free_map, free_map_next;
  ix_t              head, head_next;
  ix_t              tail, tail_next;
  ix_t              cursor, cursor_next;
  logic [CW-1:0]    count, count_next;

  logic  val_we;
  slot_t val_wa;
  val_t  val_wd;
  logic  nl_we0, nl_we1, pl_we0, pl_we1;
  slot_t nl_wa0, nl_wa1, pl_wa0, pl_wa1;
  ix_t   nl_wd0, nl_wd1, pl_wd0, pl_wd1;

  val_t    v_ext;
  logic    c_act;
  ix_t     c_succ, c_pred, t_succ, t_pred;
  logic    found;
  slot_t   free_slot;
  ix_t     new_ix;
  logic    do_ins, do_del, wipe;
  ix_t     ins_a, ins_b, del_t;
  status_t status;

  function automatic logic live(ix_t i);
    return i < NONE;
  endfunction

  function automatic slot_t slot(ix_t i);
    return i[AW-1:0];
  endfunction

  // Value shown for a node index, with this cycle's value write forwarded.
  function automatic logic [PORT_VW-1:0] view(ix_t i, val_t stored, logic we,
                                               slot_t wa, val_t wd);
    val_t v;
    v = (we && wa == slot(i)) ? wd : stored;
    return live(i) ? PORT_VW'(v) : '0;
  endfunction

  always_comb begin
    v_ext  = VALUE_WIDTH'(cmd.value);
    c_act  = live(cursor);
    c_succ = next_link[slot(cursor)];
    c_pred = prev_link[slot(cursor)];

    // Lowest free node.
    found     = 1'b0;
    free_slot = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        found     = 1'b1;
        free_slot = AW'(i);
      end
    end
    new_ix = IW'(free_slot);

    status = ST_NOP;
    do_ins = 1'b0;
    do_del = 1'b0;
    wipe   = 1'b0;
    ins_a  = NONE;
    ins_b  = NONE;
    del_t  = NONE;

    head_next     = head;
    tail_next     = tail;
    cursor_next   = cursor;
    free_map_next = free_map;
    count_next    = count;

    val_we = 1'b0;
    val_wa = slot(cursor);
    val_wd = v_ext;
    nl_we0 = 1'b0;
    nl_wa0 = free_slot;
    nl_wd0 = NONE;
    nl_we1 = 1'b0;
    nl_wa1 = free_slot;
    nl_wd1 = NONE;
    pl_we0 = 1'b0;
    pl_wa0 = free_slot;
    pl_wd0 = NONE;
    pl_we1 = 1'b0;
    pl_wa1 = free_slot;
    pl_wd1 = NONE;

    unique case (cmd.kind)
      KIND_CLEAR: begin
        wipe   = 1'b1;
        status = ST_DONE;
      end
      KIND_INS_FIRST: begin
        do_ins = 1'b1;
        ins_b  = head;
      end
      KIND_INS_LAST: begin
        do_ins = 1'b1;
        ins_a  = tail;
      end
      KIND_INS_AFTER: begin
        do_ins = c_act;
        ins_a  = cursor;
        ins_b  = c_succ;
      end
      KIND_INS_BEFORE: begin
        do_ins = c_act;
        ins_a  = c_pred;
        ins_b  = cursor;
      end
      KIND_DEL_FIRST: begin
        do_del = live(head);
        del_t  = head;
      end
      KIND_DEL_LAST: begin
        do_del = live(tail);
        del_t  = tail;
      end
      KIND_DEL_AFTER: begin
        do_del = c_act && live(c_succ);
        del_t  = c_succ;
      end
      KIND_DEL_BEFORE: begin
        do_del = c_act && live(c_pred);
        del_t  = c_pred;
      end
      KIND_GO_FIRST: begin
        cursor_next = live(head) ? head : NONE;
        status      = live(head) ? ST_DONE : ST_NOP;
      end
      KIND_GO_LAST: begin
        cursor_next = live(tail) ? tail : NONE;
        status      = live(tail) ? ST_DONE : ST_NOP;
      end
      KIND_SET: begin
        if (c_act) begin
          val_we = 1'b1;
          status = ST_DONE;
        end
      end
      KIND_NEXT: begin
        if (c_act) begin
          cursor_next = live(c_succ) ? c_succ : NONE;
          status      = ST_DONE;
        end
      end
      KIND_PREV: begin
        if (c_act) begin
          cursor_next = live(c_pred) ? c_pred : NONE;
          status      = ST_DONE;
        end
      end
      KIND_READ: begin
        status = c_act ? ST_DONE : ST_NOP;
      end
      default: begin
        status = ST_NOP;
      end
    endcase

    t_succ = next_link[slot(del_t)];
    t_pred = prev_link[slot(del_t)];

    if (do_ins) begin
      if (!found) begin
        status = ST_FULL;
      end else begin
        status = ST_DONE;
        val_we = 1'b1;
        val_wa = free_slot;
        nl_we0 = 1'b1;
        nl_wd0 = ins_b;
        pl_we0 = 1'b1;
        pl_wd0 = ins_a;
        if (live(ins_a)) begin
          nl_we1 = 1'b1;
          nl_wa1 = slot(ins_a);
          nl_wd1 = new_ix;
        end else begin
          head_next = new_ix;
        end
        if (live(ins_b)) begin
          pl_we1 = 1'b1;
          pl_wa1 = slot(ins_b);
          pl_wd1 = new_ix;
        end else begin
          tail_next = new_ix;
        end
        free_map_next[free_slot] = 1'b0;
        count_next               = count + 1'b1;
      end
    end

    if (do_del) begin
      status = ST_DONE;
      if (live(t_pred)) begin
        nl_we0 = 1'b1;
        nl_wa0 = slot(t_pred);
        nl_wd0 = t_succ;
      end else begin
        head_next = live(t_succ) ? t_succ : NONE;
      end
      if (live(t_succ)) begin
        pl_we0 = 1'b1;
        pl_wa0 = slot(t_succ);
        pl_wd0 = t_pred;
      end else begin
        tail_next = live(t_pred) ? t_pred : NONE;
      end
      if (cursor == del_t) begin
        cursor_next = NONE;
      end
      free_map_next[slot(del_t)] = 1'b1;
      if (count != '0) begin
        count_next = count - 1'b1;
      end
    end

    if (wipe) begin
      free_map_next = '1;
      head_next     = NONE;
      tail_next     = NONE;
      cursor_next   = NONE;
      count_next    = '0;
    end

    result.status       = status;
    result.is_active    = live(cursor_next);
    result.length       = LEN_W'(count_next);
    result.first_value  = view(head_next, node_store[slot(head_next)], val_we, val_wa, val_wd);
    result.last_value   = view(tail_next, node_store[slot(tail_next)], val_we, val_wa, val_wd);
    result.active_value = view(cursor_next, node_store[slot(cursor_next)], val_we, val_wa,
                               val_wd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      head     <= NONE;
      tail     <= NONE;
      cursor   <= NONE;
      count    <= '0;
    end else if (fire) begin
      free_map <= free_map_next;
      head     <= head_next;
      tail     <= tail_next;
      cursor   <= cursor_next;
      count    <= count_next;
    end
  end

  // Node entries are only written when a node is taken, relinked or set.
  always_ff @(posedge clk) begin
    if (fire && !rst) begin
      if (val_we) begin
        node_store[val_wa] <= val_wd;
      end
      if (nl_we0) begin
        next_link[nl_wa0] <= nl_wd0;
      end
      if (nl_we1) begin
        next_link[nl_wa1] <= nl_wd1;
      end
      if (pl_we0) begin
        prev_link[pl_wa0] <= pl_wd0;
      end
      if (pl_we1) begin
        prev_link[pl_wa1] <= pl_wd1;
      end
    end
  end

endmodule

### hdl/dllc_rsp_reg.sv
`timescale 1ns / 1ps

module dllc_rsp_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  dllc_pkg::rsp_t result,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dllc_pkg::rsp_t rsp
);
  import dllc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

### hdl/doubly_linked_list_cursor_engine.sv
// A command word is held in the command register until the result register can take its result word,
// which is then registered there. Throughput: one command word per cycle while results are taken; each
// command is a single pass over the node register file between the command register and the result register.
// Reset (rst, synchronous): empty list, every node free, no head, tail or cursor,
// count zero; node values and links stay unknown until written.
`timescale 1ns / 1ps
`include "doubly_linked_list_cursor_engine_defines.svh"

module doubly_linked_list_cursor_engine #(
  parameter int NODES       = dllc_pkg::NODES_DEF,
  parameter int VALUE_WIDTH = dllc_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dllc_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dllc_pkg::rsp_t rsp
);
  import dllc_pkg::*;

  logic held;
  cmd_t held_cmd;
  logic fire;
  rsp_t result;

  // A held command executes whenever the result register can take its word.
  assign fire = held && (!rsp_valid || rsp_ready);

  dllc_cmd_reg u_cmd_reg (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .fire     (fire),
    .held     (held),
    .held_cmd (held_cmd)
  );

  dllc_core #(
    .NODES      (NODES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .cmd   (held_cmd),
    .result(result)
  );

  dllc_rsp_reg u_rsp_reg (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .result   (result),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  `DLLC_ASSERT_NEXT(a_fire_gives_rsp, clk, rst, fire, rsp_valid, "executed command left no result")
  `DLLC_ASSERT_NEXT(a_clear_empties, clk, rst, fire && held_cmd.kind == KIND_CLEAR, rsp.status == ST_DONE && rsp.length == '0 && !rsp.is_active, "clear did not empty the list")
  `DLLC_ASSERT_NOW(a_empty_no_cursor, clk, rst, rsp_valid && (NODES < 32) && rsp.length == '0, !rsp.is_active, "cursor active on an empty list")
  `DLLC_ASSERT_NOW(a_stall_only_blocked, clk, rst, !cmd_ready, held && rsp_valid && !rsp_ready, "command port stalled without back pressure")

endmodule

### dv/doubly_linked_list_cursor_engine_test.sv
`timescale 1ns / 1ps

module doubly_linked_list_cursor_engine_test;
  import dllc_pkg::*;

  localparam int         NODE_CNT    = NODES_DEF;
  localparam logic [4:0] NO_NODE     = 5'(NODE_CNT);
  localparam logic [3:0] KIND_UNUSED = 4'd15;
  localparam int         HOLD_CYCLES = 60;
  localparam int         DRAIN_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Mirror of the list held by the engine.
  logic signed [31:0] node_val [NODE_CNT];
  logic [4:0]         node_next [NODE_CNT];
  logic [4:0]         node_prev [NODE_CNT];
  logic [NODE_CNT-1:0] free_nodes;
  logic [4:0] head_ix, tail_ix, cursor_ix, list_len;

  rsp_t expected_views[$];
  rsp_t want_view;
  int   words_sent = 0;
  int   words_checked = 0;
  int   fail_count = 0;
  int   kind_hits [16];
  int   full_refusals = 0;
  int   no_effects = 0;
  int   longest_list = 0;
  bit   steady = 1'b0;
  int   hold_off_req = 0;
  int   hold_off_done = 0;

  doubly_linked_list_cursor_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_node(logic [4:0] ix);
    return ix < NODE_CNT;
  endfunction

  function automatic void list_wipe();
    free_nodes = '1;
    head_ix    = NO_NODE;
    tail_ix    = NO_NODE;
    cursor_ix  = NO_NODE;
    list_len   = '0;
  endfunction

  // Takes the lowest free node and links it between a and b.
  function automatic status_t list_insert(logic signed [31:0] v, logic [4:0] a,
                                          logic [4:0] b);
    int n;
    n = -1;
    for (int i = 0; i < NODE_CNT; i++) begin
      if (free_nodes[i] && n < 0) n = i;
    end
    if (n < 0) return ST_FULL;
    free_nodes[n] = 1'b0;
    node_val[n]   = v;
    node_prev[n]  = a;
    node_next[n]  = b;
    if (is_node(a)) node_next[a] = 5'(n);
    else head_ix = 5'(n);
    if (is_node(b)) node_prev[b] = 5'(n);
    else tail_ix = 5'(n);
    list_len++;
    return ST_DONE;
  endfunction

  function automatic void list_unlink(logic [4:0] t);
    logic [4:0] a, b;
    a = node_prev[t];
    b = node_next[t];
    if (is_node(a)) node_next[a] = b;
    else head_ix = is_node(b) ? b : NO_NODE;
    if (is_node(b)) node_prev[b] = a;
    else tail_ix = is_node(a) ? a : NO_NODE;
    if (cursor_ix == t) cursor_ix = NO_NODE;
    free_nodes[t] = 1'b1;
    if (list_len > 0) list_len--;
  endfunction

  // Applies one command to the mirror and returns the view the engine must report.
  function automatic rsp_t list_apply(logic [3:0] k, logic signed [31:0] v);
    logic [4:0] c;
    bit         act;
    status_t    st;
    rsp_t       view;
    c   = cursor_ix;
    act = is_node(c);
    st  = ST_NOP;
    case (k)
      KIND_CLEAR: begin
        list_wipe();
        st = ST_DONE;
      end
      KIND_INS_FIRST: st = list_insert(v, NO_NODE, head_ix);
      KIND_INS_LAST:  st = list_insert(v, tail_ix, NO_NODE);
      KIND_GO_FIRST: begin
        cursor_ix = head_ix;
        st = is_node(head_ix) ? ST_DONE : ST_NOP;
      end
      KIND_GO_LAST: begin
        cursor_ix = tail_ix;
        st = is_node(tail_ix) ? ST_DONE : ST_NOP;
      end
      KIND_DEL_FIRST: begin
        if (is_node(head_ix)) begin
          list_unlink(head_ix);
          st = ST_DONE;
        end
      end
      KIND_DEL_LAST: begin
        if (is_node(tail_ix)) begin
          list_unlink(tail_ix);
          st = ST_DONE;
        end
      end
      KIND_DEL_AFTER: begin
        if (act && is_node(node_next[c])) begin
          list_unlink(node_next[c]);
          st = ST_DONE;
        end
      end
      KIND_DEL_BEFORE: begin
        if (act && is_node(node_prev[c])) begin
          list_unlink(node_prev[c]);
          st = ST_DONE;
        end
      end
      KIND_INS_AFTER:  if (act) st = list_insert(v, c, node_next[c]);
      KIND_INS_BEFORE: if (act) st = list_insert(v, node_prev[c], c);
      KIND_SET: begin
        if (act) begin
          node_val[c] = v;
          st = ST_DONE;
        end
      end
      KIND_NEXT: begin
        if (act) begin
          cursor_ix = is_node(node_next[c]) ? node_next[c] : NO_NODE;
          st = ST_DONE;
        end
      end
      KIND_PREV: begin
        if (act) begin
          cursor_ix = is_node(node_prev[c]) ? node_prev[c] : NO_NODE;
          st = ST_DONE;
        end
      end
      KIND_READ: st = act ? ST_DONE : ST_NOP;
      default: ;
    endcase
    view.status       = st;
    view.is_active    = is_node(cursor_ix);
    view.length       = list_len;
    view.first_value  = is_node(head_ix) ? node_val[head_ix] : '0;
    view.last_value   = is_node(tail_ix) ? node_val[tail_ix] : '0;
    view.active_value = is_node(cursor_ix) ? node_val[cursor_ix] : '0;
    return view;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR: result word %0d, %s: expected %h, got %h",
             words_checked, field, want, got);
    fail_count++;
  endtask

  // Offers one command word and waits until the engine takes it. Valid stays high
  // afterwards so that back-to-back words need no extra assignment.
  task automatic send_cmd(input logic [3:0] k, input logic signed [31:0] v);
    cmd_t word;
    rsp_t view;
    word.kind  = k;
    word.value = v;
    if (!steady && $urandom_range(99) < 17) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= word;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    view = list_apply(k, v);
    expected_views.push_back(view);
    words_sent++;
    kind_hits[k]++;
    if (view.status == ST_FULL) full_refusals++;
    if (view.status == ST_NOP) no_effects++;
    if (view.length > longest_list) longest_list = view.length;
  endtask

  // Result side: random stalls, a steady stretch, and long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_off_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off_done = hold_off_req;
      end else if (steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected result word", '0, rsp.length);
      end else begin
        want_view = expected_views.pop_front();
        if (rsp.status !== want_view.status)
          report_mismatch("status", want_view.status, rsp.status);
        if (rsp.is_active !== want_view.is_active)
          report_mismatch("is_active", want_view.is_active, rsp.is_active);
        if (rsp.length !== want_view.length)
          report_mismatch("length", want_view.length, rsp.length);
        if (rsp.first_value !== want_view.first_value)
          report_mismatch("first_value", want_view.first_value, rsp.first_value);
        if (rsp.last_value !== want_view.last_value)
          report_mismatch("last_value", want_view.last_value, rsp.last_value);
        if (rsp.active_value !== want_view.active_value)
          report_mismatch("active_value", want_view.active_value, rsp.active_value);
      end
      words_checked++;
    end
  end

  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 9)  return KIND_INS_FIRST;
    if (r < 18) return KIND_INS_LAST;
    if (r < 27) return KIND_INS_AFTER;
    if (r < 35) return KIND_INS_BEFORE;
    if (r < 40) return KIND_DEL_FIRST;
    if (r < 45) return KIND_DEL_LAST;
    if (r < 51) return KIND_DEL_AFTER;
    if (r < 57) return KIND_DEL_BEFORE;
    if (r < 63) return KIND_GO_FIRST;
    if (r < 68) return KIND_GO_LAST;
    if (r < 78) return KIND_NEXT;
    if (r < 86) return KIND_PREV;
    if (r < 92) return KIND_SET;
    if (r < 97) return KIND_READ;
    if (r < 98) return KIND_CLEAR;
    return KIND_UNUSED;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Every command that needs a node or an active cursor, and the unused kind code, issued on an empty list.
  task automatic test_empty_list();
    send_cmd(KIND_READ, '0);
    send_cmd(KIND_GO_FIRST, '0);
    send_cmd(KIND_GO_LAST, '0);
    send_cmd(KIND_DEL_FIRST, '0);
    send_cmd(KIND_DEL_LAST, '0);
    send_cmd(KIND_DEL_AFTER, '0);
    send_cmd(KIND_DEL_BEFORE, '0);
    send_cmd(KIND_INS_AFTER, 32'sh1234_5678);
    send_cmd(KIND_INS_BEFORE, 32'sh1234_5678);
    send_cmd(KIND_SET, '1);
    send_cmd(KIND_NEXT, '0);
    send_cmd(KIND_PREV, '0);
    send_cmd(KIND_UNUSED, '1);
  endtask

  // Walks the cursor off both ends and deletes the node under it and the last node.
  task automatic test_cursor_edges();
    send_cmd(KIND_INS_FIRST, 32'sh7fff_ffff);
    send_cmd(KIND_INS_LAST, 32'sh8000_0000);
    send_cmd(KIND_GO_FIRST, '0);
    send_cmd(KIND_INS_AFTER, '1);
    send_cmd(KIND_NEXT, '0);
    send_cmd(KIND_SET, 32'sh5555_aaaa);
    send_cmd(KIND_DEL_BEFORE, '0);
    send_cmd(KIND_PREV, '0);
    send_cmd(KIND_GO_LAST, '0);
    send_cmd(KIND_NEXT, '0);
    send_cmd(KIND_GO_LAST, '0);
    send_cmd(KIND_DEL_AFTER, '0);
    send_cmd(KIND_DEL_LAST, '0);
    send_cmd(KIND_DEL_FIRST, '0);
    send_cmd(KIND_CLEAR, '0);
  endtask

  // The result side holds off while inserts keep coming, so the engine backs up;
  // the burst also overfills the pool.
  task automatic test_fill_under_backpressure();
    send_cmd(KIND_CLEAR, '0);
    hold_off_req++;
    for (int i = 0; i < NODE_CNT + 4; i++)
      send_cmd((i % 2) ? KIND_INS_FIRST : KIND_INS_LAST, $urandom());
    send_cmd(KIND_GO_FIRST, '0);
    send_cmd(KIND_INS_AFTER, pick_value());
    send_cmd(KIND_INS_BEFORE, pick_value());
    send_cmd(KIND_DEL_AFTER, '0);
    send_cmd(KIND_INS_BEFORE, 32'sh0bad_cafe);
    send_cmd(KIND_READ, '0);
  endtask

  task automatic test_random_mix(input int count, input bit no_gaps);
    steady = no_gaps;
    for (int i = 0; i < count; i++)
      send_cmd(pick_kind(), pick_value());
    steady = 1'b0;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    cmd_valid <= 1'b0;
    while (expected_views.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("result words never arrived", '0, expected_views.size());
  endtask

  initial begin
    int kinds_seen;
    kinds_seen = 0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    list_wipe();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_cursor_edges();
    test_fill_under_backpressure();
    test_random_mix(200, 1'b1);
    test_random_mix(400, 1'b0);
    drain_results();

    foreach (kind_hits[i]) if (kind_hits[i] > 0) kinds_seen++;
    $display("Sent %0d command words, checked %0d results, %0d of 16 kind codes used.",
             words_sent, words_checked, kinds_seen);
    $display("Pool-full refusals: %0d, no-effect commands: %0d, longest list: %0d.",
             full_refusals, no_effects, longest_list);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("ERROR: run did not finish in time");
    $display("Test completed with failures");
    $finish;
  end

endmodule
